@@ rtl/core/s2cd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cd_pkg
// Types, constants and calendar tables for the seconds-to-date converter.
// ----------------------------------------------------------------------------
package s2cd_pkg;

   localparam int ACC_W = 32;

   localparam logic [31:0] LIMIT_SECONDS  = 32'd4102444800;
   localparam logic [31:0] DAY_SECONDS    = 32'd86400;
   localparam logic [31:0] HOUR_SECONDS   = 32'd3600;
   localparam logic [31:0] MINUTE_SECONDS = 32'd60;
   localparam logic [31:0] WEEK_DAYS      = 32'd7;
   localparam logic [31:0] YEAR_DAYS      = 32'd365;
   localparam logic [31:0] LEAP_YEAR_DAYS = 32'd366;

   localparam logic [11:0] BASE_YEAR    = 12'd1970;
   localparam logic [11:0] CENTURY_BASE = 12'd1900;

   localparam logic [3:0] JANUARY  = 4'd0;
   localparam logic [3:0] FEBRUARY = 4'd1;
   localparam logic [3:0] DECEMBER = 4'd11;

   localparam logic [3:0] DAY_STEPS    = 4'd15;
   localparam logic [3:0] HOUR_STEPS   = 4'd4;
   localparam logic [3:0] MINUTE_STEPS = 4'd5;
   localparam logic [3:0] WDAY_STEPS   = 4'd5;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DAY   = 8'b0000_0010,
      ST_HOUR  = 8'b0000_0100,
      ST_MIN   = 8'b0000_1000,
      ST_YEAR  = 8'b0001_0000,
      ST_MONTH = 8'b0010_0000,
      ST_WDAY  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
      logic        out_of_range;
   } result_type;

   // Month index runs from zero for January.
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
         4'd1:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [2:0] month_offset(input logic [3:0] month);
      logic [2:0] ofs;
      unique case (month)
         4'd0, 4'd9:        ofs = 3'd0;
         4'd1, 4'd2, 4'd10: ofs = 3'd3;
         4'd3, 4'd6:        ofs = 3'd6;
         4'd4:              ofs = 3'd1;
         4'd5:              ofs = 3'd4;
         4'd7:              ofs = 3'd2;
         4'd8, 4'd11:       ofs = 3'd5;
         default:           ofs = 3'd0;
      endcase
      return ofs;
   endfunction

endpackage

@@ rtl/core/s2cd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cd_req_if / s2cd_rsp_if
// Valid/ready channels carrying the second count and the calendar result.
// ----------------------------------------------------------------------------
interface s2cd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] second_count;

   modport source (output valid, output second_count, input ready);
   modport sink   (input valid, input second_count, output ready);
endinterface

interface s2cd_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day_of_month;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;
   logic [2:0]  weekday;
   logic        out_of_range;

   modport source (output valid, output year, output month, output day_of_month,
                   output hour, output minute, output second, output weekday,
                   output out_of_range, input ready);
   modport sink   (input valid, input year, input month, input day_of_month,
                   input hour, input minute, input second, input weekday,
                   input out_of_range, output ready);
endinterface

@@ rtl/core/s2cd_cmp_sub.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cd_cmp_sub
// Shared compare-and-subtract unit used by every step of the converter.
// ----------------------------------------------------------------------------
module s2cd_cmp_sub (
   input  logic [s2cd_pkg::ACC_W-1:0] minuend,
   input  logic [s2cd_pkg::ACC_W-1:0] subtrahend,
   output logic                       ge,
   output logic [s2cd_pkg::ACC_W-1:0] diff
);
   import s2cd_pkg::*;

   logic [ACC_W:0] wide;

   assign wide = {1'b0, minuend} - {1'b0, subtrahend};
   assign ge   = ~wide[ACC_W];
   assign diff = wide[ACC_W-1:0];

endmodule

@@ rtl/core/seconds_to_calendar_date.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Converts a count of seconds since 1970-01-01 into a Gregorian date and time.
// ----------------------------------------------------------------------------
// Usage: a transaction on req_bus carries second_count. The block then runs
// alone on it and is not ready until the result is in the output register.
// One transaction on rsp_bus returns year, month, day_of_month, hour, minute,
// second, weekday (0 is Sunday) and out_of_range for each request.
// Flow: a count past 2099-12-31 23:59:59 returns out_of_range with all
// other fields zero. Any other count runs the day division, the hour and
// minute divisions, a walk over the years since 1970, a walk over the
// months and the weekday reduction in that order, all on the single
// compare-subtract unit that every step shares. No new request is taken
// while a conversion is in progress.
// A finished result waits in the output register while rsp_bus is stalled;
// a new request is taken meanwhile and holds in its final state until the
// register frees up. Synchronous reset returns the sequencer to idle and
// drops rsp_bus.valid; no result is pending afterwards.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date (
   input logic         clock,
   input logic         reset,
   s2cd_req_if.sink    req_bus,
   s2cd_rsp_if.source  rsp_bus
);
   import s2cd_pkg::*;

   state_type        state_ff, state_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [15:0]      quo_ff, quo_in;
   logic [3:0]       step_ff, step_in;
   logic [15:0]      days_ff, days_in;
   logic [11:0]      year_ff, year_in;
   logic [3:0]       month_ff, month_in;
   result_type       work_ff, work_in;
   result_type       res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [ACC_W-1:0] operand;
   logic [ACC_W-1:0] diff;
   logic             ge;
   logic [ACC_W-1:0] acc_next;
   logic [15:0]      quo_next;
   logic             leap;
   logic [11:0]      century_ofs;
   logic [7:0]       lo;
   logic [4:0]       day_value;
   logic [8:0]       wday_sum;
   logic             adjust;
   logic             req_fire;
   logic             load_result;

   s2cd_cmp_sub u_cmp_sub (
      .minuend    (acc_ff),
      .subtrahend (operand),
      .ge         (ge),
      .diff       (diff)
   );

   // Only 2000 is a century year in 1970..2099, and it is a leap year.
   assign leap = (year_ff[1:0] == 2'b00);

   always_comb begin
      case (state_ff)
         ST_DAY:   operand = DAY_SECONDS << step_ff;
         ST_HOUR:  operand = HOUR_SECONDS << step_ff;
         ST_MIN:   operand = MINUTE_SECONDS << step_ff;
         ST_YEAR:  operand = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
         ST_MONTH: operand = {27'd0, month_len(month_ff, leap)};
         ST_WDAY:  operand = WEEK_DAYS << step_ff;
         default:  operand = DAY_SECONDS;
      endcase
   end

   assign acc_next = ge ? diff : acc_ff;
   assign quo_next = {quo_ff[14:0], ge};

   assign century_ofs = year_ff - CENTURY_BASE;
   assign lo          = century_ofs[7:0];
   assign day_value   = acc_ff[4:0] + 5'd1;
   assign adjust      = (lo[1:0] == 2'b00) && (month_ff <= FEBRUARY);
   assign wday_sum    = {1'b0, lo} + {3'b000, lo[7:2]} + {4'd0, day_value}
                        + {6'd0, month_offset(month_ff)} - {8'd0, adjust};

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign load_result   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      days_in  = days_ff;
      year_in  = year_ff;
      month_in = month_ff;
      work_in  = work_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               work_in = '0;
               if (req_bus.second_count >= LIMIT_SECONDS) begin
                  work_in.out_of_range = 1'b1;
                  state_in             = ST_DONE;
               end else begin
                  acc_in   = req_bus.second_count;
                  quo_in   = '0;
                  step_in  = DAY_STEPS;
                  state_in = ST_DAY;
               end
            end
         end
         ST_DAY: begin
            acc_in  = acc_next;
            quo_in  = quo_next;
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               days_in  = quo_next;
               quo_in   = '0;
               step_in  = HOUR_STEPS;
               state_in = ST_HOUR;
            end
         end
         ST_HOUR: begin
            acc_in  = acc_next;
            quo_in  = quo_next;
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               work_in.hour = quo_next[4:0];
               quo_in       = '0;
               step_in      = MINUTE_STEPS;
               state_in     = ST_MIN;
            end
         end
         ST_MIN: begin
            acc_in  = acc_next;
            quo_in  = quo_next;
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               work_in.minute = quo_next[5:0];
               work_in.second = acc_next[5:0];
               acc_in         = {16'd0, days_ff};
               year_in        = BASE_YEAR;
               state_in       = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (ge) begin
               acc_in  = diff;
               year_in = year_ff + 12'd1;
            end else begin
               month_in = JANUARY;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (!ge || month_ff == DECEMBER) begin
               work_in.year         = year_ff;
               work_in.month        = month_ff + 4'd1;
               work_in.day_of_month = day_value;
               acc_in               = {23'd0, wday_sum};
               step_in              = WDAY_STEPS;
               state_in             = ST_WDAY;
            end else begin
               acc_in   = diff;
               month_in = month_ff + 4'd1;
            end
         end
         ST_WDAY: begin
            acc_in  = acc_next;
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               work_in.weekday = acc_next[2:0];
               state_in        = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_result) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_result) begin
         res_in       = work_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      days_ff  <= days_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      work_ff  <= work_in;
      res_ff   <= res_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.year         = res_ff.year;
   assign rsp_bus.month        = res_ff.month;
   assign rsp_bus.day_of_month = res_ff.day_of_month;
   assign rsp_bus.hour         = res_ff.hour;
   assign rsp_bus.minute       = res_ff.minute;
   assign rsp_bus.second       = res_ff.second;
   assign rsp_bus.weekday      = res_ff.weekday;
   assign rsp_bus.out_of_range = res_ff.out_of_range;

`ifndef SYNTHESIS
   a_in_range_starts_division: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.second_count < LIMIT_SECONDS) |=> (state_ff == ST_DAY))
      else $error("in-range request did not start the day division");

   a_year_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YEAR) |-> (year_ff >= BASE_YEAR && year_ff <= 12'd2099))
      else $error("year walk left the supported range");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_ff.out_of_range) |->
         (res_ff.year == 12'd0 && res_ff.month == 4'd0 && res_ff.weekday == 3'd0))
      else $error("out-of-range result carries nonzero fields");

   a_valid_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !res_ff.out_of_range) |->
         (res_ff.month >= 4'd1 && res_ff.month <= 4'd12 &&
          res_ff.day_of_month != 5'd0 && res_ff.weekday <= 3'd6))
      else $error("in-range result holds an impossible date");
`endif

endmodule
